// ----- rtl/core/pge_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pge_pkg: shared constants and types for the potassium gate Euler step core
// Fixed-point constants, config register codes, divider handshake types and
// the 2^(k/DEPTH) exponential ROM built at elaboration.
// ----------------------------------------------------------------------------
package pge_pkg;

    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_FRAC_W      = 32 - EXP_IDX_W;

    localparam logic [33:0] LOG2E_Q32 = 34'h171547653;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;

    localparam logic [16:0] ALPHA_LIMIT    = 17'd6554;
    localparam logic [16:0] ALPHA_MAX      = 17'd131071;
    localparam logic [16:0] PROB_ONE       = 17'd65536;
    localparam logic [15:0] TIME_STEP_RST  = 16'd655;
    localparam logic [16:0] GATE_START_RST = 17'd20821;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_START = 1'b1;

    // bit-serial divider
    localparam int DIV_W     = 72;
    localparam int DIV_BITS  = 40;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } t_div_rsp;

    typedef logic [31:0] t_exp_rom [EXP_TABLE_DEPTH];

    // entry k = round(2^31 * 2^(k/DEPTH)), truncated Taylor series of e^y
    function automatic t_exp_rom f_build_exp_rom();
        t_exp_rom     rom;
        logic [127:0] y;
        logic [127:0] term;
        logic [127:0] sum;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            y    = (128'(k) * 128'(LN2_Q32)) >> EXP_IDX_W;
            term = 128'd1 << 32;
            sum  = 128'd1 << 32;
            for (int n = 1; n < 40; n++) begin
                term = ((term * y) >> 32) / 128'(n);
                sum  = sum + term;
            end
            rom[k] = 32'((sum + 128'd1) >> 1);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = f_build_exp_rom();

endpackage
`default_nettype wire

// ----- rtl/core/pge_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pge_div: restoring bit-serial divider
// Remainder starts at a given value, then one dividend bit is shifted in
// per cycle (MSB first) and one quotient bit is produced per cycle.
// ----------------------------------------------------------------------------
module pge_div import pge_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_div_req            i_req,
    input  wire logic [DIV_W-1:0]    i_rem_init,
    input  wire logic [DIV_BITS-1:0] i_bits,
    input  wire logic [DIV_W-1:0]    i_divisor,
    output t_div_rsp                 o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_BITS-1:0]  r_bits;
    logic [DIV_BITS-1:0]  r_quot;

    logic [DIV_W-1:0] w_trial;
    logic             w_ge;

    assign w_trial = {r_rem[DIV_W-2:0], r_bits[DIV_BITS-1]};
    assign w_ge    = (w_trial >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
                r_rem  <= i_rem_init;
                r_bits <= i_bits;
                r_div  <= i_divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_trial - r_div) : w_trial;
                r_quot <= {r_quot[DIV_BITS-2:0], w_ge};
                r_bits <= {r_bits[DIV_BITS-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
`default_nettype wire

// ----- rtl/core/potassium_gate_euler_step_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// potassium_gate_euler_step_core: HH potassium n-gate forward Euler update
// Usage: one voltage item in (signed Q7.8 mV) per simulation step; one item
// out with updated n, alpha, beta (Q1.16) and a saturation flag.
// Input channel i_in_valid/o_in_ready, output channel o_out_valid/i_out_ready.
// One item at a time: o_in_ready is high only while the sequencer is idle.
// From accept to o_out_valid: the power arguments (S_PROD, S_FRAC, S_DIV5,
// S_TARG; the /2560 scaling is a split multiply plus a reciprocal multiply
// by 1/5 on the shared multiplier), an exp evaluation, the alpha setup and
// the 17-step bit-serial alpha divide, a second exp evaluation, then beta
// and update. Special alpha cases skip the divide.
// Result sits in an output register; a new item may be accepted while it
// waits. If the receiver stalls, the final update step holds until the
// output register is free, so nothing is lost or overwritten.
// Config (i_cfg_we) is taken any cycle; write only while idle. Writing
// gate_start loads the stored n at once (saturated to 1.0).
// Reset (synchronous, low): dt = 655, n = 20821, outputs invalid, no
// clearing pass (the exp table is a constant ROM).
// ----------------------------------------------------------------------------
module potassium_gate_euler_step_core import pge_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic signed [15:0]    i_voltage,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [16:0]                o_gate_value,
    output logic [16:0]                o_open_rate,
    output logic [16:0]                o_close_rate,
    output logic                       o_clamped,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_PROD, S_FRAC, S_DIV5, S_TARG,
        S_PW_PREP, S_PW_RDA, S_PW_RDB, S_PW_MUL, S_PW_SHIFT,
        S_AL_PREP, S_AL_NUM, S_AL_CHK, S_AL_W, S_BETA,
        S_PA, S_PB, S_PDIF, S_Q, S_UPD
    } t_state;

    localparam logic signed [41:0] T_LO   = -42'sd171798691840;
    localparam logic signed [41:0] T_HI   = 42'sd124554051584;
    localparam logic signed [41:0] T_BIAS = 42'sd274877906944;
    localparam logic signed [41:0] L2E_42 = 42'(LOG2E_Q32);

    // log2e = 2560 * L2E_INT + L2E_REM; RECIP5 = ceil(2^20/5), exact below 2^18
    localparam logic [21:0] L2E_INT = 22'd2420440;
    localparam logic [10:0] L2E_REM = 11'd1619;
    localparam logic [17:0] RECIP5  = 18'd209716;

    t_state                  r_state;
    logic [15:0]             r_time_step;
    logic [16:0]             r_n;
    logic signed [15:0]      r_v;
    logic [36:0]             r_qa;
    logic [25:0]             r_y;
    logic [16:0]             r_qb;
    logic signed [41:0]      r_t1;
    logic signed [41:0]      r_t2;
    logic                    r_sel;
    logic [EXP_IDX_W-1:0]    r_idx;
    logic [EXP_FRAC_W-1:0]   r_rfrac;
    logic signed [7:0]       r_sh;
    logic [31:0]             r_rom_q;
    logic [31:0]             r_a;
    logic                    r_last;
    logic [32:0]             r_dlt;
    logic [63:0]             r_e1;
    logic [63:0]             r_e2;
    logic [DIV_W-1:0]        r_ud;
    logic [DIV_W-1:0]        r_numer;
    logic [16:0]             r_un;
    logic                    r_al_lim;
    logic                    r_al_zero;
    logic [16:0]             r_alpha;
    logic [16:0]             r_beta;
    logic [34:0]             r_pa;
    logic [33:0]             r_pb;
    logic signed [35:0]      r_p;
    logic signed [51:0]      r_q;
    logic                    r_out_valid;
    logic [16:0]             r_out_gate;
    logic [16:0]             r_out_alpha;
    logic [16:0]             r_out_beta;
    logic                    r_out_clamped;

    // shared multiplier
    logic signed [35:0] w_ma;
    logic signed [33:0] w_mb;
    logic signed [69:0] w_mp;

    // exp helpers
    logic signed [41:0] w_t;
    logic signed [41:0] w_tc;
    logic        [41:0] w_u;
    logic [EXP_IDX_W-1:0] w_rom_addr;
    logic [32:0]        w_b;
    logic [32:0]        w_dab;
    logic [32:0]        w_m;
    logic [5:0]         w_rs;
    logic [63:0]        w_pow;

    // alpha helpers
    logic signed [17:0] w_num;
    logic signed [64:0] w_den;
    logic [63:0]        w_den_abs;

    // divider
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    logic [DIV_W-1:0]   w_div_rem;
    logic [DIV_BITS-1:0] w_div_bits;
    logic [DIV_W-1:0]   w_div_dvs;
    logic [15:0]        w_vabs;
    logic signed [41:0] w_q1;
    logic signed [41:0] w_q2;

    // update helpers
    logic [51:0]        w_mag;
    logic [19:0]        w_d;
    logic signed [20:0] w_nn;
    logic               w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_vabs = r_v[15] ? 16'(-r_v) : 16'(r_v);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_PROD: begin
                w_ma = $signed({20'b0, w_vabs});
                w_mb = $signed({12'b0, L2E_INT});
            end
            S_FRAC: begin
                w_ma = $signed({20'b0, w_vabs});
                w_mb = $signed({23'b0, L2E_REM});
            end
            S_DIV5: begin
                w_ma = $signed({19'b0, r_y[25:9]});
                w_mb = $signed({16'b0, RECIP5});
            end
            S_PW_MUL: begin
                w_ma = $signed({4'b0, r_rfrac, {EXP_IDX_W{1'b0}}});
                w_mb = $signed({1'b0, w_dab});
            end
            S_PA: begin
                w_ma = $signed({19'b0, 17'(PROB_ONE - r_n)});
                w_mb = $signed({17'b0, r_alpha});
            end
            S_PB: begin
                w_ma = $signed({19'b0, r_n});
                w_mb = $signed({17'b0, r_beta});
            end
            S_Q: begin
                w_ma = r_p;
                w_mb = $signed({18'b0, r_time_step});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mp = w_ma * w_mb;

    // power argument clamp and split
    assign w_t  = r_sel ? r_t2 : r_t1;
    assign w_tc = (w_t < T_LO) ? T_LO : ((w_t > T_HI) ? T_HI : w_t);
    assign w_u  = 42'(w_tc + T_BIAS);

    assign w_rom_addr = (r_state == S_PW_RDB) ? (r_idx + 1'b1) : r_idx;

    always_ff @(posedge i_clk) begin
        r_rom_q <= EXP_ROM[w_rom_addr];
    end

    // right neighbor; past the last entry it is 2.0 in Q1.31
    assign w_b   = r_last ? 33'h1_0000_0000 : {1'b0, r_rom_q};
    assign w_dab = (w_b > {1'b0, r_a}) ? (w_b - {1'b0, r_a}) : '0;

    assign w_m  = {1'b0, r_a} + r_dlt;
    assign w_rs = 6'(-r_sh);
    always_comb begin
        if (!r_sh[7]) begin
            w_pow = 64'(w_m) << r_sh[4:0];
        end else begin
            w_pow = (64'(w_m) + (64'd1 << (w_rs - 1'b1))) >> w_rs;
        end
    end

    assign w_num     = 18'sd2560 - 18'(r_v);
    assign w_den     = $signed({1'b0, r_e1}) - 65'sh1_0000_0000;
    assign w_den_abs = w_den[64] ? 64'(-w_den) : 64'(w_den);

    // |v * log2e| / 2560 truncated; the /20480 one is three bits further down
    assign w_q1 = $signed({5'b0, r_qa + 37'(r_qb)});
    assign w_q2 = w_q1 >>> 3;

    always_comb begin
        w_div_req  = '0;
        w_div_rem  = '0;
        w_div_bits = '0;
        w_div_dvs  = '0;
        if (r_state == S_AL_CHK) begin
            w_div_req.start = !r_al_lim && !r_al_zero && (r_numer[DIV_W-1:17] < r_ud);
            w_div_req.count = DIV_CNT_W'(17);
            w_div_rem       = DIV_W'(r_numer[DIV_W-1:17]);
            w_div_bits      = {r_numer[16:0], 23'b0};
            w_div_dvs       = r_ud;
        end
    end

    pge_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_rem_init (w_div_rem),
        .i_bits     (w_div_bits),
        .i_divisor  (w_div_dvs),
        .o_rsp      (w_div_rsp)
    );

    // Euler increment, rounded half away from zero
    assign w_mag = r_q[51] ? 52'(-r_q) : 52'(r_q);
    assign w_d   = 20'((w_mag + 52'h8000_0000) >> 32);
    assign w_nn  = r_q[51] ? ($signed({4'b0, r_n}) - $signed({1'b0, w_d}))
                           : ($signed({4'b0, r_n}) + $signed({1'b0, w_d}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time_step <= TIME_STEP_RST;
            r_n         <= GATE_START_RST;
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_UPD)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TIME_STEP:  r_time_step <= i_cfg_data[15:0];
                    CFG_GATE_START: r_n <= (i_cfg_data > PROB_ONE) ? PROB_ONE : i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_v     <= i_voltage;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_qa    <= w_mp[36:0];
                    r_state <= S_FRAC;
                end
                S_FRAC: begin
                    r_y     <= w_mp[25:0];
                    r_state <= S_DIV5;
                end
                S_DIV5: begin
                    r_qb    <= w_mp[36:20];
                    r_state <= S_TARG;
                end
                S_TARG: begin
                    // trunc toward zero: sign applied to magnitude quotient
                    r_t1    <= r_v[15] ? (L2E_42 + w_q1) : (L2E_42 - w_q1);
                    r_t2    <= r_v[15] ? w_q2 : -w_q2;
                    r_sel   <= 1'b0;
                    r_state <= S_PW_PREP;
                end
                S_PW_PREP: begin
                    r_idx   <= w_u[31 -: EXP_IDX_W];
                    r_rfrac <= w_u[EXP_FRAC_W-1:0];
                    r_sh    <= $signed({1'b0, w_u[38:32]}) - 8'sd63;
                    r_state <= S_PW_RDA;
                end
                S_PW_RDA: r_state <= S_PW_RDB;
                S_PW_RDB: begin
                    r_a     <= r_rom_q;
                    r_last  <= &r_idx;
                    r_state <= S_PW_MUL;
                end
                S_PW_MUL: begin
                    r_dlt   <= 33'(w_mp[64:32]);
                    r_state <= S_PW_SHIFT;
                end
                S_PW_SHIFT: begin
                    if (!r_sel) begin
                        r_e1    <= w_pow;
                        r_state <= S_AL_PREP;
                    end else begin
                        r_e2    <= w_pow;
                        r_state <= S_BETA;
                    end
                end
                S_AL_PREP: begin
                    r_ud      <= (DIV_W'(w_den_abs) << 6) + (DIV_W'(w_den_abs) << 5)
                               + (DIV_W'(w_den_abs) << 2);
                    r_un      <= w_num[17] ? 17'(-w_num) : 17'(w_num);
                    r_al_lim  <= (w_num == 18'sd0) || (w_den == 65'sd0);
                    r_al_zero <= (w_num > 18'sd0) != (w_den > 65'sd0);
                    r_state   <= S_AL_NUM;
                end
                S_AL_NUM: begin
                    r_numer <= (DIV_W'(r_un) << 40) + (r_ud >> 1);
                    r_state <= S_AL_CHK;
                end
                S_AL_CHK: begin
                    if (r_al_lim) begin
                        r_alpha <= ALPHA_LIMIT;
                        r_sel   <= 1'b1;
                        r_state <= S_PW_PREP;
                    end else if (r_al_zero) begin
                        r_alpha <= '0;
                        r_sel   <= 1'b1;
                        r_state <= S_PW_PREP;
                    end else if (r_numer[DIV_W-1:17] >= r_ud) begin
                        r_alpha <= ALPHA_MAX;
                        r_sel   <= 1'b1;
                        r_state <= S_PW_PREP;
                    end else begin
                        r_state <= S_AL_W;
                    end
                end
                S_AL_W: begin
                    if (w_div_rsp.done) begin
                        r_alpha <= w_div_rsp.quot[16:0];
                        r_sel   <= 1'b1;
                        r_state <= S_PW_PREP;
                    end
                end
                S_BETA: begin
                    r_beta  <= (((r_e2 + 64'h4_0000) >> 19) > 64'(PROB_ONE))
                             ? PROB_ONE : 17'((r_e2 + 64'h4_0000) >> 19);
                    r_state <= S_PA;
                end
                S_PA: begin
                    r_pa    <= 35'(w_mp);
                    r_state <= S_PB;
                end
                S_PB: begin
                    r_pb    <= 34'(w_mp);
                    r_state <= S_PDIF;
                end
                S_PDIF: begin
                    r_p     <= $signed({1'b0, r_pa}) - $signed({2'b0, r_pb});
                    r_state <= S_Q;
                end
                S_Q: begin
                    r_q     <= 52'(w_mp);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_out_free) begin
                        if (w_nn < 21'sd0) begin
                            r_n           <= '0;
                            r_out_gate    <= '0;
                            r_out_clamped <= 1'b1;
                        end else if (w_nn > $signed({4'b0, PROB_ONE})) begin
                            r_n           <= PROB_ONE;
                            r_out_gate    <= PROB_ONE;
                            r_out_clamped <= 1'b1;
                        end else begin
                            r_n           <= 17'(w_nn);
                            r_out_gate    <= 17'(w_nn);
                            r_out_clamped <= 1'b0;
                        end
                        r_out_alpha <= r_alpha;
                        r_out_beta  <= r_beta;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_gate_value = r_out_gate;
    assign o_open_rate  = r_out_alpha;
    assign o_close_rate = r_out_beta;
    assign o_clamped    = r_out_clamped;

    a_n_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= PROB_ONE)
        else $error("stored gate probability above 1.0");

    a_clamp_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clamped) |-> (o_gate_value == '0 || o_gate_value == PROB_ONE))
        else $error("clamped item not at a rail");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_AL_W))
        else $error("divider finished outside a wait state");

endmodule
`default_nettype wire
